>>> rtl/ddgr_pkg.sv
package ddgr_pkg;

   // value width of every unit count
   localparam int VAL_W = 16;
   localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

   // command codes
   localparam logic [1:0] CMD_LOAD_PROC  = 2'd0;
   localparam logic [1:0] CMD_LOAD_AVAIL = 2'd1;
   localparam logic [1:0] CMD_START      = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_REDUCED  = 2'd0;
   localparam logic [1:0] STATUS_SAFE     = 2'd1;
   localparam logic [1:0] STATUS_DEADLOCK = 2'd2;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [2:0]       proc_index;
      logic [1:0]       res_index;
      logic [VAL_W-1:0] alloc_value;
      logic [VAL_W-1:0] req_value;
      logic [VAL_W-1:0] avail_value;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] finished_proc;
      logic [3:0] finished_count;
      logic       last;
   } rsp_payload_type;

   // one memory word: allocation and request of one process for one type
   typedef struct packed {
      logic [VAL_W-1:0] alloc;
      logic [VAL_W-1:0] request;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_ADD_RD,
      ST_ADD_WR
   } state_type;

endpackage

>>> rtl/ddgr_ram.sv
module ddgr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/deadlock_detection_graph_reduction_core.sv
// channel   ports                        direction  beat accepted when
// request   start, busy, req_data        in         start && !busy
// result    rsp_strobe, rsp_data         out        rsp_strobe (one cycle, no stall)
//
// a load beat is taken in ST_IDLE; busy stays low and the next beat may follow at once
// after reset a clearing pass zeroes all NUM_PROCS*NUM_RES words of the entry memory
// a run reads then compares each resource of an unfinished process until a miss,
// skips finished processes in the read state, and reads then writes each resource
// per reduction, paced by the one entry-RAM read port; busy is high for the whole run
// results are strobed for one cycle each and the receiver cannot stall them
module deadlock_detection_graph_reduction_core #(
   parameter int NUM_PROCS = 8,
   parameter int NUM_RES   = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  ddgr_pkg::req_payload_type req_data,
   output logic                     rsp_strobe,
   output ddgr_pkg::rsp_payload_type rsp_data
);

   localparam int DEPTH = NUM_PROCS * NUM_RES;
   localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int PW    = NUM_PROCS > 1 ? $clog2(NUM_PROCS) : 1;
   localparam int RW    = NUM_RES > 1 ? $clog2(NUM_RES) : 1;
   localparam int CW    = $clog2(NUM_PROCS + 1);
   localparam int VW    = ddgr_pkg::VAL_W;
   localparam int EW    = $bits(ddgr_pkg::entry_type);

   ddgr_pkg::state_type state_ff, state_in;

   logic [AW-1:0]  clr_addr_ff, clr_addr_in;
   logic [PW-1:0]  p_ff, p_in;
   logic [RW-1:0]  j_ff, j_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [VW-1:0]  avail_ff [NUM_RES];
   logic [VW-1:0]  avail_in [NUM_RES];
   logic [VW-1:0]  work_ff [NUM_RES];
   logic [VW-1:0]  work_in [NUM_RES];
   logic [NUM_PROCS-1:0] finish_ff, finish_in;
   logic           rsp_strobe_ff, rsp_strobe_in;
   ddgr_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   ddgr_pkg::entry_type   ram_wr_data;
   logic [AW-1:0]         ram_rd_addr;
   logic [EW-1:0]         ram_rd_raw;
   ddgr_pkg::entry_type   ram_rd_data;

   logic           last_p;
   logic           last_j;
   logic           last_clr;
   logic           req_miss;
   logic [VW:0]    sum;
   logic [VW-1:0]  sum_sat;
   logic           accept;
   logic           load_ok;

   // entry memory, allocation and request side by side
   ddgr_ram #(
      .WIDTH(EW),
      .DEPTH(DEPTH)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(EW'(ram_wr_data)),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_raw)
   );

   assign ram_rd_data = ddgr_pkg::entry_type'(ram_rd_raw);

   // shared conditions
   assign accept   = start && !busy;
   assign last_p   = p_ff == PW'(NUM_PROCS - 1);
   assign last_j   = j_ff == RW'(NUM_RES - 1);
   assign last_clr = clr_addr_ff == AW'(DEPTH - 1);
   assign req_miss = ram_rd_data.request > work_ff[j_ff];
   assign sum      = {1'b0, work_ff[j_ff]} + {1'b0, ram_rd_data.alloc};
   assign sum_sat  = sum[VW] ? ddgr_pkg::VAL_MAX : sum[VW-1:0];
   assign load_ok  = (32'(req_data.proc_index) < NUM_PROCS) &&
                     (32'(req_data.res_index) < NUM_RES);
   assign ram_rd_addr = AW'(32'(p_ff) * NUM_RES + 32'(j_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ddgr_pkg::ST_CLEAR: begin
            if (last_clr) state_in = ddgr_pkg::ST_IDLE;
         end
         ddgr_pkg::ST_IDLE: begin
            if (accept && req_data.cmd == ddgr_pkg::CMD_START) begin
               state_in = ddgr_pkg::ST_SCAN_RD;
            end
         end
         ddgr_pkg::ST_SCAN_RD: begin
            if (finish_ff[p_ff]) begin
               if (last_p) state_in = ddgr_pkg::ST_IDLE;
            end else begin
               state_in = ddgr_pkg::ST_SCAN_CMP;
            end
         end
         ddgr_pkg::ST_SCAN_CMP: begin
            if (req_miss) begin
               state_in = last_p ? ddgr_pkg::ST_IDLE : ddgr_pkg::ST_SCAN_RD;
            end else begin
               state_in = last_j ? ddgr_pkg::ST_ADD_RD : ddgr_pkg::ST_SCAN_RD;
            end
         end
         ddgr_pkg::ST_ADD_RD: begin
            state_in = ddgr_pkg::ST_ADD_WR;
         end
         ddgr_pkg::ST_ADD_WR: begin
            state_in = last_j ? ddgr_pkg::ST_SCAN_RD : ddgr_pkg::ST_ADD_RD;
         end
         default: begin
            state_in = ddgr_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      clr_addr_in   = clr_addr_ff;
      p_in          = p_ff;
      j_in          = j_ff;
      count_in      = count_ff;
      avail_in      = avail_ff;
      work_in       = work_ff;
      finish_in     = finish_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = AW'(32'(req_data.proc_index) * NUM_RES + 32'(req_data.res_index));
      ram_wr_data.alloc   = req_data.alloc_value;
      ram_wr_data.request = req_data.req_value;

      // final status beat of a run
      if (((state_ff == ddgr_pkg::ST_SCAN_RD) && finish_ff[p_ff] && last_p) ||
          ((state_ff == ddgr_pkg::ST_SCAN_CMP) && req_miss && last_p)) begin
         rsp_strobe_in              = 1'b1;
         rsp_data_in.status         = (count_ff == CW'(NUM_PROCS)) ?
                                      ddgr_pkg::STATUS_SAFE : ddgr_pkg::STATUS_DEADLOCK;
         rsp_data_in.finished_proc  = 3'd0;
         rsp_data_in.finished_count = 4'(count_ff);
         rsp_data_in.last           = 1'b1;
      end

      unique case (state_ff)
         ddgr_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
         end
         ddgr_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_data.cmd)
                  ddgr_pkg::CMD_LOAD_PROC: begin
                     ram_wr_en = load_ok;
                  end
                  ddgr_pkg::CMD_LOAD_AVAIL: begin
                     if (32'(req_data.res_index) < NUM_RES) begin
                        avail_in[RW'(req_data.res_index)] = req_data.avail_value;
                     end
                  end
                  ddgr_pkg::CMD_START: begin
                     work_in   = avail_ff;
                     finish_in = '0;
                     count_in  = '0;
                     p_in      = '0;
                     j_in      = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ddgr_pkg::ST_SCAN_RD: begin
            // skip processes already reduced
            if (finish_ff[p_ff] && !last_p) p_in = p_ff + PW'(1);
         end
         ddgr_pkg::ST_SCAN_CMP: begin
            if (req_miss) begin
               j_in = '0;
               if (!last_p) p_in = p_ff + PW'(1);
            end else begin
               j_in = last_j ? '0 : j_ff + RW'(1);
            end
         end
         ddgr_pkg::ST_ADD_RD: begin
         end
         ddgr_pkg::ST_ADD_WR: begin
            // release the process's allocation into work
            work_in[j_ff] = sum_sat;
            if (last_j) begin
               j_in                       = '0;
               p_in                       = '0;
               finish_in[p_ff]            = 1'b1;
               count_in                   = count_ff + CW'(1);
               rsp_strobe_in              = 1'b1;
               rsp_data_in.status         = ddgr_pkg::STATUS_REDUCED;
               rsp_data_in.finished_proc  = 3'(p_ff);
               rsp_data_in.finished_count = 4'(count_ff + CW'(1));
               rsp_data_in.last           = 1'b0;
            end else begin
               j_in = j_ff + RW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ddgr_pkg::ST_CLEAR;
         clr_addr_ff   <= '0;
         p_ff          <= '0;
         j_ff          <= '0;
         count_ff      <= '0;
         finish_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < NUM_RES; i++) begin
            avail_ff[i] <= '0;
            work_ff[i]  <= '0;
         end
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         p_ff          <= p_in;
         j_ff          <= j_in;
         count_ff      <= count_in;
         finish_ff     <= finish_in;
         rsp_strobe_ff <= rsp_strobe_in;
         avail_ff      <= avail_in;
         work_ff       <= work_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = state_ff != ddgr_pkg::ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
